>>> src/bsr_pkg.sv
// bsr_pkg: shared constants, word types and helpers for the BEV rasterizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bsr_pkg;

    // Grid and table sizing
    localparam int HALF_EXTENT = 32;
    localparam int MAX_ACTORS  = 16;

    localparam int ADDR_W = (MAX_ACTORS > 1) ? $clog2(MAX_ACTORS) : 1;
    localparam int CNT_W  = $clog2(MAX_ACTORS + 1);

    // Pixel centre offset in Q8.8: centre = idx*256 - PIX_OFS
    localparam int PIX_OFS = HALF_EXTENT * 256 - 128;
    // Signed width of a pixel centre coordinate (col/row are 6 bits)
    localparam int PX_W = $clog2(HALF_EXTENT * 256 + 16384) + 1;
    // Offset from actor centre, products, and their sums
    localparam int D_W = ((PX_W > 16) ? PX_W : 16) + 1;
    localparam int P_W = 2 * D_W;
    localparam int S_W = P_W + 1;

    // Commands
    localparam logic [1:0] CMD_CLEAR    = 2'd0;
    localparam logic [1:0] CMD_LOAD     = 2'd1;
    localparam logic [1:0] CMD_CLASSIFY = 2'd2;

    // Actor kinds
    localparam logic KIND_CAR = 1'b0;
    localparam logic KIND_PED = 1'b1;

    // Terrain tiles
    localparam logic [2:0] TILE_DRIVABLE = 3'd0;
    localparam logic [2:0] TILE_LANE     = 3'd1;

    // Pixel classes
    localparam logic [2:0] CLS_DRIVABLE   = 3'd0;
    localparam logic [2:0] CLS_LANE       = 3'd1;
    localparam logic [2:0] CLS_OBSTACLE   = 3'd2;
    localparam logic [2:0] CLS_VEHICLE    = 3'd3;
    localparam logic [2:0] CLS_PEDESTRIAN = 3'd4;

    // Configuration register indexes and reset values
    localparam logic [1:0] REG_CAR_HALF_LEN = 2'd0;
    localparam logic [1:0] REG_CAR_HALF_WID = 2'd1;
    localparam logic [1:0] REG_PED_RAD_SQ   = 2'd2;

    localparam logic [15:0] RST_CAR_HALF_LEN = 16'd576;
    localparam logic [15:0] RST_CAR_HALF_WID = 16'd320;
    localparam logic [31:0] RST_PED_RAD_SQ   = 32'd36864;

    typedef struct packed {
        logic [1:0]         command;
        logic               actor_kind;
        logic signed [15:0] actor_pos_x;
        logic signed [15:0] actor_pos_y;
        logic signed [15:0] heading_cosine;
        logic signed [15:0] heading_sine;
        logic [2:0]         tile_kind;
        logic [5:0]         pixel_col;
        logic [5:0]         pixel_row;
    } bsr_in_t;

    typedef struct packed {
        logic [2:0] pixel_class;
        logic [5:0] out_col;
        logic [5:0] out_row;
    } bsr_out_t;

    // One actor table entry
    typedef struct packed {
        logic               kind;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] cosine;
        logic signed [15:0] sine;
    } bsr_actor_t;

    typedef struct packed {
        logic [15:0] car_half_length;
        logic [15:0] car_half_width;
        logic [31:0] ped_radius_sq;
    } bsr_cfg_t;

    // Per-actor test outcome from the geometry pipe
    typedef struct packed {
        logic valid;
        logic car;
        logic ped;
    } bsr_hit_t;

    function automatic logic [2:0] terrain_class(input logic [2:0] tile);
        logic [2:0] cls;
        case (tile)
            TILE_DRIVABLE: cls = CLS_DRIVABLE;
            TILE_LANE:     cls = CLS_LANE;
            default:       cls = CLS_OBSTACLE;
        endcase
        return cls;
    endfunction

endpackage

>>> src/bsr_actor_ram.sv
// bsr_actor_ram: actor table, one write and one registered read port.
// Depends on bsr_pkg for the entry type and address width.
`timescale 1ns / 1ps

module bsr_actor_ram
    import bsr_pkg::*;
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  bsr_actor_t        wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output bsr_actor_t        rdata
);

    bsr_actor_t mem [0:MAX_ACTORS-1];
    bsr_actor_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> src/bsr_geom.sv
// bsr_geom: three-stage actor test pipe (offset, multiply, compare).
// Depends on bsr_pkg for widths and the entry, config and hit types.
`timescale 1ns / 1ps

module bsr_geom
    import bsr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  bsr_actor_t             actor,
    input  logic signed [PX_W-1:0] px,
    input  logic signed [PX_W-1:0] py,
    input  bsr_cfg_t               cfg,
    output bsr_hit_t               hit,
    output logic                   active
);

    // stage A: offsets
    logic                  a_valid_reg;
    logic                  a_kind_reg;
    logic signed [D_W-1:0] dx_reg, dy_reg, c_reg, s_reg;
    logic signed [D_W-1:0] dx_next, dy_next;

    // stage B: products
    logic                  b_valid_reg;
    logic                  b_kind_reg;
    logic signed [P_W-1:0] pa_reg, pb_reg, pc_reg, pd_reg;
    logic signed [D_W-1:0] op_a0, op_a1, op_b0, op_b1;

    // stage C: compare
    bsr_hit_t              hit_reg;
    bsr_hit_t              hit_next;
    logic signed [S_W-1:0] sum_ab, dif_cd;
    logic [S_W-1:0]        mag_l, mag_w, lim_l, lim_w, rad_sq;

    always_comb
    begin
        dx_next = D_W'(px) - D_W'(actor.pos_x);
        dy_next = D_W'(py) - D_W'(actor.pos_y);
    end

    // Cars: c*dx, s*dy, c*dy, s*dx. Pedestrians: dx*dx, dy*dy.
    always_comb
    begin
        if (a_kind_reg == KIND_PED)
        begin
            op_a0 = dx_reg;
            op_a1 = dx_reg;
            op_b0 = dy_reg;
            op_b1 = dy_reg;
        end
        else
        begin
            op_a0 = c_reg;
            op_a1 = dx_reg;
            op_b0 = s_reg;
            op_b1 = dy_reg;
        end
    end

    always_comb
    begin
        sum_ab   = S_W'(pa_reg) + S_W'(pb_reg);
        dif_cd   = S_W'(pc_reg) - S_W'(pd_reg);
        mag_l    = sum_ab[S_W-1] ? S_W'(-sum_ab) : S_W'(sum_ab);
        mag_w    = dif_cd[S_W-1] ? S_W'(-dif_cd) : S_W'(dif_cd);
        lim_l    = S_W'({cfg.car_half_length, 14'd0});
        lim_w    = S_W'({cfg.car_half_width, 14'd0});
        rad_sq   = S_W'(cfg.ped_radius_sq);
        hit_next.valid = b_valid_reg;
        hit_next.car   = b_valid_reg && (b_kind_reg == KIND_CAR)
                         && (mag_l <= lim_l) && (mag_w <= lim_w);
        // sum of squares is never negative
        hit_next.ped   = b_valid_reg && (b_kind_reg == KIND_PED)
                         && (S_W'(sum_ab) <= rad_sq);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            hit_reg     <= '0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            hit_reg     <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_kind_reg <= actor.kind;
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        c_reg      <= D_W'(actor.cosine);
        s_reg      <= D_W'(actor.sine);
        b_kind_reg <= a_kind_reg;
        pa_reg     <= op_a0 * op_a1;
        pb_reg     <= op_b0 * op_b1;
        pc_reg     <= c_reg * dy_reg;
        pd_reg     <= s_reg * dx_reg;
    end

    assign hit    = hit_reg;
    assign active = a_valid_reg | b_valid_reg | hit_reg.valid;

endmodule

>>> src/bev_semantic_rasterizer.sv
// bev_semantic_rasterizer: top level, command sequencer and config registers.
// Depends on bsr_pkg, bsr_actor_ram and bsr_geom.
`timescale 1ns / 1ps

// Labels pixels of a top-down grid from a terrain tile and a table of up to
// MAX_ACTORS actors. A word is accepted when start is high and busy is low.
// Clear and load complete at the accepting edge and never raise busy; a load
// into a full table is dropped. A classify word raises busy and the block then
// streams the stored actors, one per cycle, out of the actor RAM through a
// three-stage test pipe (offset, multiply, compare). busy stays high while the
// actors are scanned and until the pipe has drained; with an empty table the
// scan is skipped. When busy drops, done pulses for exactly one cycle with the
// result word. The receiver cannot stall: the result is lost if not taken in
// that cycle. Config writes (cfg_write) take effect at once and are only meant
// to happen while the block is idle.

module bev_semantic_rasterizer
    import bsr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  bsr_in_t     item,
    output logic        done,
    output bsr_out_t    result,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t          state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic            rd_valid_reg;
    logic            car_acc_reg, car_acc_next;
    logic            ped_acc_reg, ped_acc_next;
    logic            done_reg, done_next;
    bsr_out_t        result_reg, result_next;
    bsr_cfg_t        cfg_reg;

    // pixel being classified
    logic [2:0]             tile_cls_reg, tile_cls_next;
    logic [5:0]             col_reg, col_next;
    logic [5:0]             row_reg, row_next;
    logic signed [PX_W-1:0] px_reg, px_next;
    logic signed [PX_W-1:0] py_reg, py_next;

    logic       accept;
    logic       ram_we, ram_re;
    bsr_actor_t ram_wdata, ram_rdata;
    bsr_hit_t   hit;
    logic       pipe_active;

    assign accept = start && (state_reg == ST_IDLE);

    // --- actor table ---
    always_comb
    begin
        ram_we          = accept && (item.command == CMD_LOAD)
                          && (count_reg < CNT_W'(MAX_ACTORS));
        ram_wdata.kind   = item.actor_kind;
        ram_wdata.pos_x  = item.actor_pos_x;
        ram_wdata.pos_y  = item.actor_pos_y;
        ram_wdata.cosine = item.heading_cosine;
        ram_wdata.sine   = item.heading_sine;
        ram_re          = (state_reg == ST_SCAN);
    end

    bsr_actor_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[ADDR_W-1:0]),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    bsr_geom u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rd_valid_reg),
        .actor    (ram_rdata),
        .px       (px_reg),
        .py       (py_reg),
        .cfg      (cfg_reg),
        .hit      (hit),
        .active   (pipe_active)
    );

    // --- sequencer ---
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        idx_next      = idx_reg;
        car_acc_next  = car_acc_reg | hit.car;
        ped_acc_next  = ped_acc_reg | hit.ped;
        done_next     = 1'b0;
        result_next   = result_reg;
        tile_cls_next = tile_cls_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        px_next       = px_reg;
        py_next       = py_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (item.command)
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_LOAD:
                        begin
                            if (ram_we)
                            begin
                                count_next = count_reg + 1'b1;
                            end
                        end
                        CMD_CLASSIFY:
                        begin
                            tile_cls_next = terrain_class(item.tile_kind);
                            col_next      = item.pixel_col;
                            row_next      = item.pixel_row;
                            px_next       = PX_W'({item.pixel_col, 8'd0})
                                            - PX_W'(PIX_OFS);
                            py_next       = PX_W'(PIX_OFS)
                                            - PX_W'({item.pixel_row, 8'd0});
                            idx_next      = '0;
                            car_acc_next  = 1'b0;
                            ped_acc_next  = 1'b0;
                            state_next    = (count_reg == '0) ? ST_DRAIN : ST_SCAN;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_SCAN:
            begin
                idx_next = idx_reg + 1'b1;
                if (idx_reg == CNT_W'(count_reg - 1'b1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                // wait until the last actor's outcome is folded in
                if (!rd_valid_reg && !pipe_active)
                begin
                    done_next               = 1'b1;
                    result_next.out_col     = col_reg;
                    result_next.out_row     = row_reg;
                    result_next.pixel_class = ped_acc_reg ? CLS_PEDESTRIAN :
                                              car_acc_reg ? CLS_VEHICLE :
                                              tile_cls_reg;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            idx_reg      <= '0;
            rd_valid_reg <= 1'b0;
            car_acc_reg  <= 1'b0;
            ped_acc_reg  <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            idx_reg      <= idx_next;
            rd_valid_reg <= ram_re;
            car_acc_reg  <= car_acc_next;
            ped_acc_reg  <= ped_acc_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tile_cls_reg <= tile_cls_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
    end

    // --- config registers ---
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.car_half_length <= RST_CAR_HALF_LEN;
            cfg_reg.car_half_width  <= RST_CAR_HALF_WID;
            cfg_reg.ped_radius_sq   <= RST_PED_RAD_SQ;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_CAR_HALF_LEN: cfg_reg.car_half_length <= cfg_data[15:0];
                REG_CAR_HALF_WID: cfg_reg.car_half_width  <= cfg_data[15:0];
                REG_PED_RAD_SQ:   cfg_reg.ped_radius_sq   <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

>>> src/bsr_checker.sv
// bsr_checker: port-level checks on the rasterizer's command handshake.
// Depends on bsr_pkg; bound to bev_semantic_rasterizer below.
`timescale 1ns / 1ps

module bsr_checker
    import bsr_pkg::*;
(
    input logic     clk,
    input logic     rst_n,
    input logic     start,
    input logic     busy,
    input bsr_in_t  item,
    input logic     done
);

    // a classify word always occupies the block
    a_classify_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.command == CMD_CLASSIFY) |=> busy)
        else $error("classify did not raise busy");

    // clear, load and unused codes finish at the accepting edge
    a_other_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.command != CMD_CLASSIFY) |=> !busy)
        else $error("non-classify word raised busy");

    // every classify ends with exactly one result
    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result while busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

endmodule

bind bev_semantic_rasterizer bsr_checker u_bsr_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .item  (item),
    .done  (done)
);

>>> dv/testbench.sv
// testbench: self-checking bench for the BEV semantic rasterizer.
// Depends on bsr_pkg and bev_semantic_rasterizer, which needs bsr_actor_ram and bsr_geom.
`timescale 1ns / 1ps

module testbench;
    import bsr_pkg::*;

    // Codes the package does not name
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam logic [2:0] TILE_SIDEWALK = 3'd2;
    localparam logic [2:0] TILE_OBSTACLE = 3'd3;
    localparam logic [2:0] TILE_OFF_MAP  = 3'd4;

    localparam int  SETTLE_CYCLES = MAX_ACTORS + 8;  // longest busy window plus margin
    localparam int  DRAIN_LIMIT   = 4000;
    localparam int  CYCLE_LIMIT   = 600000;
    localparam real PI            = 3.14159265358979;

    // A staged word; hold makes the driver wait until every label is back
    typedef struct {
        bsr_in_t w;
        bit      hold;
    } staged_word_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        start     = 1'b0;
    bsr_in_t     item      = '0;
    logic        cfg_write = 1'b0;
    logic [1:0]  cfg_index = REG_CAR_HALF_LEN;
    logic [31:0] cfg_data  = '0;
    logic        busy;
    logic        done;
    bsr_out_t    result;

    bev_semantic_rasterizer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Bench-side copy of the block: register values and the actor table
    logic [15:0] half_len = RST_CAR_HALF_LEN;
    logic [15:0] half_wid = RST_CAR_HALF_WID;
    logic [31:0] ped_r2   = RST_PED_RAD_SQ;
    bsr_actor_t  actor_table [MAX_ACTORS];
    int          actor_count = 0;

    staged_word_t word_queue[$];
    bsr_out_t     expected_labels[$];

    int idle_pct   = 0;
    int calm_words = 0;
    int error_count = 0;
    int n_clear = 0, n_load = 0, n_dropped = 0, n_classify = 0, n_unused = 0;
    int labels_checked = 0;
    int phases_run = 0;

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Expected label of one classify word against the current table.
    // Offsets and rotated offsets are exact: Q8.8 x Q1.14 lands on Q.22.
    function automatic bsr_out_t label_pixel(input bsr_in_t w);
        longint   px, py, dx, dy, lx, ly, d2, lim_l, lim_w, c, s;
        logic     car_hit, ped_hit;
        bsr_out_t lbl;
        px      = longint'(w.pixel_col) * 256 - HALF_EXTENT * 256 + 128;
        py      = HALF_EXTENT * 256 - longint'(w.pixel_row) * 256 - 128;
        lim_l   = longint'(half_len) * 16384;
        lim_w   = longint'(half_wid) * 16384;
        car_hit = 1'b0;
        ped_hit = 1'b0;
        for (int i = 0; i < actor_count; i++) begin
            dx = px - longint'(actor_table[i].pos_x);
            dy = py - longint'(actor_table[i].pos_y);
            if (actor_table[i].kind == KIND_CAR) begin
                c  = longint'(actor_table[i].cosine);
                s  = longint'(actor_table[i].sine);
                lx = c * dx + s * dy;
                ly = c * dy - s * dx;
                if (lx < 0) lx = -lx;
                if (ly < 0) ly = -ly;
                if (lx <= lim_l && ly <= lim_w) car_hit = 1'b1;
            end else begin
                d2 = dx * dx + dy * dy;
                if (d2 <= longint'(ped_r2)) ped_hit = 1'b1;
            end
        end
        // terrain first; unknown tiles fall in with sidewalk as obstacle
        case (w.tile_kind)
            TILE_DRIVABLE: lbl.pixel_class = CLS_DRIVABLE;
            TILE_LANE:     lbl.pixel_class = CLS_LANE;
            default:       lbl.pixel_class = CLS_OBSTACLE;
        endcase
        if (car_hit) lbl.pixel_class = CLS_VEHICLE;
        if (ped_hit) lbl.pixel_class = CLS_PEDESTRIAN;
        lbl.out_col = w.pixel_col;
        lbl.out_row = w.pixel_row;
        return lbl;
    endfunction

    // Apply one accepted word to the bench copy of the block
    task automatic absorb_word(input bsr_in_t w);
        case (w.command)
            CMD_CLEAR: begin
                actor_count = 0;
                n_clear++;
            end
            CMD_LOAD: begin
                n_load++;
                if (actor_count < MAX_ACTORS) begin
                    actor_table[actor_count].kind   = w.actor_kind;
                    actor_table[actor_count].pos_x  = w.actor_pos_x;
                    actor_table[actor_count].pos_y  = w.actor_pos_y;
                    actor_table[actor_count].cosine = w.heading_cosine;
                    actor_table[actor_count].sine   = w.heading_sine;
                    actor_count++;
                end else begin
                    n_dropped++;  // full table: load is ignored
                end
            end
            CMD_CLASSIFY: begin
                expected_labels.push_back(label_pixel(w));
                n_classify++;
            end
            default: n_unused++;
        endcase
    endtask

    // Driver: presents staged words, holds each until start && !busy at an edge.
    // One NBA per signal per edge; start stays high across back-to-back words.
    always @(posedge clk) begin
        logic         next_start;
        bsr_in_t      next_item;
        staged_word_t head;
        logic         wait_drain;
        next_start = start;
        next_item  = item;
        if (rst_n) begin
            if (start && !busy) begin
                absorb_word(item);
                next_start = 1'b0;
            end
            if (!next_start && word_queue.size() != 0) begin
                head       = word_queue[0];
                wait_drain = head.hold && (expected_labels.size() != 0 || busy);
                if (!wait_drain && (calm_words > 0 || $urandom_range(99) >= idle_pct)) begin
                    head       = word_queue.pop_front();
                    next_start = 1'b1;
                    next_item  = head.w;
                    // occasional bursts with no gaps even in the idling phases
                    if (calm_words > 0)
                        calm_words--;
                    else if (idle_pct != 0 && $urandom_range(99) < 3)
                        calm_words = $urandom_range(20, 50);
                end
            end
        end
        start <= next_start;
        item  <= next_item;
    end

    // Monitor: a label is valid for the one cycle done is high
    always @(posedge clk) begin
        bsr_out_t want;
        if (rst_n && done === 1'b1) begin
            if (expected_labels.size() == 0) begin
                flag_error($sformatf("label class %0d at (%0d,%0d) with no classify pending",
                                     result.pixel_class, result.out_col, result.out_row));
            end else begin
                want = expected_labels.pop_front();
                labels_checked++;
                if (result.pixel_class !== want.pixel_class)
                    flag_error($sformatf("pixel (%0d,%0d): class %0d, expected %0d",
                                         want.out_col, want.out_row,
                                         result.pixel_class, want.pixel_class));
                if (result.out_col !== want.out_col)
                    flag_error($sformatf("column %0d, expected %0d",
                                         result.out_col, want.out_col));
                if (result.out_row !== want.out_row)
                    flag_error($sformatf("row %0d, expected %0d",
                                         result.out_row, want.out_row));
            end
        end
    end

    function automatic bsr_in_t make_word(input logic [1:0] cmd, input logic kind,
                                          input int x, input int y, input int c, input int s,
                                          input int tile, input int col, input int row);
        bsr_in_t w;
        w.command        = cmd;
        w.actor_kind     = kind;
        w.actor_pos_x    = x[15:0];
        w.actor_pos_y    = y[15:0];
        w.heading_cosine = c[15:0];
        w.heading_sine   = s[15:0];
        w.tile_kind      = tile[2:0];
        w.pixel_col      = col[5:0];
        w.pixel_row      = row[5:0];
        return w;
    endfunction

    task automatic stage(input bsr_in_t w, input bit hold);
        staged_word_t sw;
        sw.w    = w;
        sw.hold = hold;
        word_queue.push_back(sw);
    endtask

    function automatic int clamp_cell(input int v);
        return (v < 0) ? 0 : (v > 63) ? 63 : v;
    endfunction

    // Random scenes: mostly clear / load a few actors / classify pixels near
    // them, so the geometry tests actually fire; the rest is raw noise and
    // tables overfilled past MAX_ACTORS.
    task automatic add_random(input int target);
        int      added, n_act, n_pix, pick, col, row, jit, c, s;
        int      ax [24];
        int      ay [24];
        real     ang;
        bsr_in_t w;
        added = 0;
        while (added < target) begin
            if ($urandom_range(99) < 8) begin
                w = make_word($urandom_range(3), $urandom_range(1), $urandom, $urandom,
                              $urandom, $urandom, $urandom_range(7),
                              $urandom_range(63), $urandom_range(63));
                stage(w, 1'b0);
                if (w.command != CMD_UNUSED) added++;
            end else begin
                if ($urandom_range(99) < 80) begin
                    stage(make_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0),
                          $urandom_range(99) < 10);
                    added++;
                end
                n_act = ($urandom_range(99) < 10) ? $urandom_range(14, 20)
                                                   : $urandom_range(1, 5);
                for (int k = 0; k < n_act; k++) begin
                    col = $urandom_range(63);
                    row = $urandom_range(63);
                    // 30% per axis sit on a pixel centre (zero-size boxes hit)
                    jit = ($urandom_range(99) < 30) ? 0 : $urandom_range(1024);
                    ax[k] = col * 256 - PIX_OFS + ((jit == 0) ? 0 : jit - 512);
                    jit = ($urandom_range(99) < 30) ? 0 : $urandom_range(1024);
                    ay[k] = PIX_OFS - row * 256 + ((jit == 0) ? 0 : jit - 512);
                    if ($urandom_range(99) < 10) begin
                        c = $urandom;  // any heading the field holds
                        s = $urandom;
                    end else begin
                        ang = $urandom_range(359) * PI / 180.0;
                        c   = $rtoi($cos(ang) * 16384.0);
                        s   = $rtoi($sin(ang) * 16384.0);
                    end
                    stage(make_word(CMD_LOAD, $urandom_range(1), ax[k], ay[k], c, s,
                                    $urandom_range(7), $urandom_range(63),
                                    $urandom_range(63)), 1'b0);
                    added++;
                end
                n_pix = $urandom_range(4, 12);
                for (int k = 0; k < n_pix; k++) begin
                    if ($urandom_range(99) < 20) begin
                        col = $urandom_range(63);
                        row = $urandom_range(63);
                    end else begin
                        pick = $urandom_range(n_act - 1);
                        jit  = $urandom_range(8);
                        col  = clamp_cell(((ax[pick] + PIX_OFS + 128) >>> 8) + jit - 4);
                        jit  = $urandom_range(8);
                        row  = clamp_cell(((PIX_OFS - ay[pick] + 128) >>> 8) + jit - 4);
                    end
                    stage(make_word(CMD_CLASSIFY, $urandom_range(1), $urandom, $urandom,
                                    $urandom, $urandom, $urandom_range(7), col, row), 1'b0);
                    added++;
                end
            end
        end
    endtask

    // Short directed opening: every tile code at the grid corners, the unused
    // command, extreme and unnormalised actors, an inclusive box edge, and a
    // clear that waits for all labels before it goes in.
    task automatic add_directed();
        stage(make_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0);
        for (int t = 0; t < 8; t++)
            stage(make_word(CMD_CLASSIFY, 0, 0, 0, 0, 0, t,
                            t[0] ? 63 : 0, t[1] ? 63 : 0), 1'b0);
        stage(make_word(CMD_UNUSED, 1, -1, -1, -1, -1, 7, 63, 63), 1'b0);
        // car centred on pixel (0,0), pedestrian on (63,63)
        stage(make_word(CMD_LOAD, KIND_CAR, -PIX_OFS, PIX_OFS, 16384, 0, 0, 0, 0), 1'b0);
        stage(make_word(CMD_LOAD, KIND_PED, PIX_OFS, -PIX_OFS, 0, 0, 0, 0, 0), 1'b0);
        // car whose box end lands exactly on the centre of pixel (10,10)
        stage(make_word(CMD_LOAD, KIND_CAR, 10 * 256 - PIX_OFS - RST_CAR_HALF_LEN,
                        PIX_OFS - 10 * 256, 16384, 0, 0, 0, 0), 1'b0);
        stage(make_word(CMD_LOAD, KIND_CAR, -32768, 32767, -32768, 32767,
                        TILE_OFF_MAP, 0, 0), 1'b0);
        stage(make_word(CMD_LOAD, KIND_PED, 32767, -32768, 16384, -16384,
                        TILE_SIDEWALK, 63, 63), 1'b0);
        stage(make_word(CMD_CLASSIFY, 0, 0, 0, 0, 0, TILE_OBSTACLE, 0, 0), 1'b0);
        stage(make_word(CMD_CLASSIFY, 0, 0, 0, 0, 0, TILE_LANE, 63, 63), 1'b0);
        stage(make_word(CMD_CLASSIFY, 0, 0, 0, 0, 0, TILE_DRIVABLE, 10, 10), 1'b0);
        stage(make_word(CMD_CLASSIFY, 0, 0, 0, 0, 0, TILE_SIDEWALK, 1, 0), 1'b0);
        stage(make_word(CMD_CLEAR, 1, -1, -1, -1, -1, 7, 63, 63), 1'b1);
        stage(make_word(CMD_CLASSIFY, 0, 0, 0, 0, 0, TILE_DRIVABLE, 0, 0), 1'b0);
    endtask

    // Wait until every staged word is in and every label is back, then let
    // the pipe run dry; polled on the falling edge to stay clear of the driver.
    task automatic settle();
        while (word_queue.size() != 0 || start) @(negedge clk);
        while (expected_labels.size() != 0 || busy) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        case (idx)
            REG_CAR_HALF_LEN: half_len = data[15:0];
            REG_CAR_HALF_WID: half_wid = data[15:0];
            REG_PED_RAD_SQ:   ped_r2   = data;
            default: ;
        endcase
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Upper bits of the 16-bit registers get junk; the block must drop them
    task automatic program_regs(input logic [15:0] len, input logic [15:0] wid,
                                input logic [31:0] r2);
        logic [31:0] junk;
        junk = $urandom;
        write_reg(REG_CAR_HALF_LEN, {junk[31:16], len});
        junk = $urandom;
        write_reg(REG_CAR_HALF_WID, {junk[31:16], wid});
        write_reg(REG_PED_RAD_SQ, r2);
    endtask

    task automatic run_phase(input int idle, input int words);
        idle_pct = idle;
        add_random(words);
        settle();
        phases_run++;
    endtask

    // Watchdog on total cycles
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("timeout after %0d cycles, %0d labels outstanding",
                 CYCLE_LIMIT, expected_labels.size());
        $display("bev_semantic_rasterizer verification failed");
        $finish;
    end

    initial begin
        int n;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // reset register values, sender never idle
        add_directed();
        run_phase(0, 230);

        // every register at its top value, sender idle about 45% of cycles
        program_regs(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_phase(45, 270);

        // zero-size boxes and discs: only exact centre hits; the receiver
        // cannot stall, so this phase runs with the sender flat out
        program_regs(16'h0000, 16'h0000, 32'h0000_0000);
        run_phase(0, 270);

        // random mid-range sizes, sender idle about 38%
        program_regs($urandom_range(256, 1500), $urandom_range(128, 800),
                     $urandom_range(10000, 300000));
        run_phase(38, 270);

        // back to the reset values, written explicitly
        program_regs(RST_CAR_HALF_LEN, RST_CAR_HALF_WID, RST_PED_RAD_SQ);
        idle_pct = 38;
        add_random(260);
        while (word_queue.size() != 0 || start) @(negedge clk);
        for (n = 0; n < DRAIN_LIMIT && (expected_labels.size() != 0 || busy); n++)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        phases_run++;

        if (expected_labels.size() != 0)
            flag_error($sformatf("%0d labels never came back", expected_labels.size()));

        $display("covered %0d words over %0d register settings: %0d clear, %0d load"
                 , n_clear + n_load + n_classify + n_unused, phases_run, n_clear, n_load);
        $display("  (%0d dropped on a full table), %0d classify, %0d unused; %0d labels checked"
                 , n_dropped, n_classify, n_unused, labels_checked);
        if (error_count == 0)
            $display("bev_semantic_rasterizer verification clean");
        else
            $display("bev_semantic_rasterizer verification failed");
        $finish;
    end

endmodule

>>> sim.f
src/bsr_pkg.sv
src/bsr_actor_ram.sv
src/bsr_geom.sv
src/bev_semantic_rasterizer.sv
src/bsr_checker.sv
dv/testbench.sv
